// ----- hdl/fmt_pkg.sv -----
// Shared types, constants and helper functions of the number to ASCII formatter.
package fmt_pkg;

    // Default depth of the command queue between front and back.
    localparam int FMT_QUEUE_DEPTH = 2;

    // Input mode codes.
    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_HEX      = 2'd2;

    // Digit positions of the decimal sequence.
    localparam logic [2:0] POS_TEN_THOUSANDS = 3'd0;
    localparam logic [2:0] POS_THOUSANDS     = 3'd1;
    localparam logic [2:0] POS_HUNDREDS      = 3'd2;
    localparam logic [2:0] POS_TENS          = 3'd3;
    localparam logic [2:0] POS_UNITS         = 3'd4;

    // Character constants.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [3:0] NIBBLE_NINE = 4'h9;
    localparam logic [3:0] NIBBLE_TEN  = 4'hA;

    // One input beat.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
    } fmt_in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } fmt_out_t;

    // Kind of work that the back end carries out.
    typedef enum logic [1:0] {
        KIND_DEC,
        KIND_SDEC,
        KIND_HEX
    } fmt_kind_t;

    // Classified command handed from front to back.
    typedef struct packed {
        fmt_kind_t   kind;
        logic [7:0]  sign_char;
        logic [15:0] num;
    } fmt_cmd_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DEC,
        ST_HEX_HI,
        ST_HEX_LO
    } back_state_t;

    // Weight of a decimal position times a digit.
    function automatic logic [16:0] dec_multiple(input logic [2:0] pos, input logic [3:0] k);
        logic [16:0] w;
        begin
            case (pos)
                POS_TEN_THOUSANDS: w = 17'd10000;
                POS_THOUSANDS:     w = 17'd1000;
                POS_HUNDREDS:      w = 17'd100;
                POS_TENS:          w = 17'd10;
                default:           w = 17'd1;
            endcase
            dec_multiple = 17'(w * {13'd0, k});
        end
    endfunction

    // Uppercase hex character of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        begin
            if (nibble <= NIBBLE_NINE) begin
                hex_char = CHAR_ZERO + {4'd0, nibble};
            end else begin
                hex_char = CHAR_A + {4'd0, nibble - NIBBLE_TEN};
            end
        end
    endfunction

endpackage

// ----- hdl/fmt_front.sv -----
// Front end: takes input beats, classifies them and builds back end commands.
module fmt_front (
    input  logic              start,
    input  logic              busy,
    input  fmt_pkg::fmt_in_t  item,
    output logic              push,
    output fmt_pkg::fmt_cmd_t cmd
);
    import fmt_pkg::*;

    logic accept;

    assign accept = start && !busy;

    // Classify the mode and form the magnitude and sign character.
    always_comb
    begin
        push          = 1'b0;
        cmd.kind      = KIND_DEC;
        cmd.sign_char = CHAR_SPACE;
        cmd.num       = item.value;
        case (item.mode)
            MODE_UNSIGNED:
            begin
                push = accept;
            end
            MODE_SIGNED:
            begin
                push     = accept;
                cmd.kind = KIND_SDEC;
                if (item.value[15])
                begin
                    cmd.sign_char = CHAR_MINUS;
                    cmd.num       = 16'((~item.value) + 16'd1);
                end
            end
            MODE_HEX:
            begin
                push     = accept;
                cmd.kind = KIND_HEX;
                cmd.num  = {8'd0, item.value[7:0]};
            end
            default:
            begin
                // An undefined mode is taken and dropped.
                push = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/fmt_queue.sv -----
// Short command queue that decouples the front end from the back end.
module fmt_queue #(
    parameter int DEPTH = fmt_pkg::FMT_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fmt_pkg::fmt_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output fmt_pkg::fmt_cmd_t head_cmd
);
    import fmt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fmt_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/fmt_back.sv -----
// Back end: sequences the characters of one command, one digit per cycle.
module fmt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  fmt_pkg::fmt_cmd_t cmd,
    output logic              pop,
    output logic              result_valid,
    output fmt_pkg::fmt_out_t result
);
    import fmt_pkg::*;

    back_state_t state_reg, state_next;
    logic [15:0] num_reg, num_next;
    logic [2:0]  pos_reg, pos_next;
    logic        started_reg, started_next;
    logic [7:0]  sign_reg, sign_next;
    logic        result_valid_reg, result_valid_next;
    fmt_out_t    result_reg, result_next;

    logic [3:0]  digit;
    logic [15:0] remainder;
    logic        show;

    // Digit of the current position by parallel compares against its multiples.
    always_comb
    begin
        digit = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({1'b0, num_reg} >= dec_multiple(pos_reg, 4'(k)))
            begin
                digit = 4'(k);
            end
        end
        remainder = 16'({1'b0, num_reg} - dec_multiple(pos_reg, digit));
        show      = (digit != 4'd0) || started_reg || (pos_reg >= POS_TENS);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_HEX)
                    begin
                        state_next = ST_HEX_HI;
                    end else if (cmd.kind == KIND_SDEC)
                    begin
                        state_next = ST_SIGN;
                    end else
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_SIGN:   state_next = ST_DEC;
            ST_DEC:
            begin
                if (pos_reg == POS_UNITS)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HEX_HI: state_next = ST_HEX_LO;
            ST_HEX_LO: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        pop                   = 1'b0;
        num_next              = num_reg;
        pos_next              = pos_reg;
        started_next          = started_reg;
        sign_next             = sign_reg;
        result_valid_next     = 1'b0;
        result_next.text_char = result_reg.text_char;
        result_next.last      = result_reg.last;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop          = 1'b1;
                    num_next     = cmd.num;
                    pos_next     = POS_TEN_THOUSANDS;
                    started_next = 1'b0;
                    sign_next    = cmd.sign_char;
                end
            end
            ST_SIGN:
            begin
                result_valid_next     = 1'b1;
                result_next.text_char = sign_reg;
                result_next.last      = 1'b0;
            end
            ST_DEC:
            begin
                result_valid_next     = show;
                result_next.text_char = CHAR_ZERO + {4'd0, digit};
                result_next.last      = (pos_reg == POS_UNITS);
                num_next              = remainder;
                started_next          = show;
                pos_next              = pos_reg + 3'd1;
            end
            ST_HEX_HI:
            begin
                result_valid_next     = 1'b1;
                result_next.text_char = hex_char(num_reg[7:4]);
                result_next.last      = 1'b0;
            end
            ST_HEX_LO:
            begin
                result_valid_next     = 1'b1;
                result_next.text_char = hex_char(num_reg[3:0]);
                result_next.last      = 1'b1;
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        pos_reg     <= pos_next;
        started_reg <= started_next;
        sign_reg    <= sign_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The decimal position never runs past the units digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC) |-> (pos_reg <= POS_UNITS))
        else $error("decimal position out of range");

    // By the tens digit the remaining value is below one hundred.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC && pos_reg == POS_TENS) |-> (num_reg < 16'd100))
        else $error("remainder too large at tens digit");

    // A command is taken only while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && cmd_valid))
        else $error("command popped while busy");

    // The last character of a run returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_next && result_next.last) |=> (state_reg == ST_IDLE))
        else $error("run ended without returning to idle");

endmodule

// ----- hdl/number_to_ascii_formatter_unit.sv -----
// Top level of the number to ASCII formatter: front end, command queue and back end.
//
// Usage:
//   A beat on the input channel is taken at a rising edge where start is high
//   and busy is low. item.mode selects unsigned decimal, signed decimal with a
//   leading '-' or space, or the low byte as two uppercase hex digits; an
//   undefined mode is taken and yields no characters.
//   Each character leaves on result for exactly one cycle, marked by
//   result_valid, with result.last set on the final character of a run. The
//   receiver cannot stall, so no back pressure reaches the result side.
//   Path: an input beat is written into the command queue, the idle back end
//   pops it into its state and datapath registers, and the first character
//   is then registered onto result; each suppressed leading digit of an
//   unsigned decimal item delays it further.
//   Sequencing: the back end takes a command in its idle state, then one step
//   per decimal position (five) after a sign step for a signed item, or the
//   ST_HEX_HI and ST_HEX_LO steps for hex; suppressed zeros still take a step.
//   A new command is taken only when idle; busy rises only when the queue is full.
//   Reset clears the queue and returns the sequencer to idle; no character
//   is in flight afterwards.
module number_to_ascii_formatter_unit #(
    parameter int QUEUE_DEPTH = fmt_pkg::FMT_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fmt_pkg::fmt_in_t  item,
    output logic              result_valid,
    output fmt_pkg::fmt_out_t result
);
    import fmt_pkg::*;

    logic     push;
    fmt_cmd_t push_cmd;
    logic     pop;
    logic     q_full;
    logic     q_not_empty;
    fmt_cmd_t head_cmd;

    assign busy = q_full;

    fmt_front u_front (
        .start (start),
        .busy  (busy),
        .item  (item),
        .push  (push),
        .cmd   (push_cmd)
    );

    fmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    fmt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_not_empty),
        .cmd          (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
